FILE: sv/mpld_pkg.sv
// Package for the multiplexed PWM LED dimmer: item modes, parameter defaults,
// scan tables and the charlieplex line decode.
// No dependencies; the top level and the testbench import it.
`default_nettype none

package mpld_pkg;

    // Parameter defaults for the top level
    localparam int DEF_NUM_LEDS = 16;
    localparam int DEF_LEVELS   = 16;
    localparam int DEF_ROWS     = 6;
    localparam int DEF_PHASES   = 96;

    // Fixed sizes
    localparam int MAX_LEDS    = 16;
    localparam int LEVEL_W     = 5;
    localparam int SLOT_COUNT  = 6;
    localparam int SLOT_AW     = 3;
    localparam int SLOT_W      = 3;
    localparam int LINE_W      = 3;
    localparam int ROW_TAB_W   = 4;
    localparam int COL_TAB_W   = 8;
    localparam int IN_DATA_W   = 16;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_LEVEL = 2'd1,
        MODE_SET_SLOT  = 2'd2,
        MODE_CLEAR     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [LINE_W-1:0] high;
        logic [LINE_W-1:0] enable;
    } lines_t;

    // Scrambled column order across one PWM frame
    localparam logic [3:0] COL_ORDER [MAX_LEDS] = '{
        4'd0, 4'd8, 4'd4, 4'd12, 4'd1, 4'd9, 4'd5, 4'd13,
        4'd2, 4'd10, 4'd6, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15
    };

    // Fixed scan row of each direct LED
    localparam logic [ROW_TAB_W-1:0] LED_ROW [MAX_LEDS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4,
        4'd5, 4'd0, 4'd1, 4'd2, 4'd0, 4'd2, 4'd3, 4'd5
    };

    // Position of a column in the scrambled order; MAX_LEDS when absent
    function automatic logic [LEVEL_W-1:0] col_rank(input logic [COL_TAB_W-1:0] col);
        logic [LEVEL_W-1:0] rank;
        rank = LEVEL_W'(MAX_LEDS);
        for (int i = 0; i < MAX_LEDS; i++) begin
            if (col == COL_TAB_W'(COL_ORDER[i])) begin
                rank = LEVEL_W'(i);
            end
        end
        return rank;
    endfunction

    // Charlieplex LED number to line enable and drive-high bits
    function automatic lines_t charlie_decode(input logic [SLOT_W-1:0] v);
        lines_t l;
        unique case (v)
            3'd1:    begin l.enable = 3'b011; l.high = 3'b001; end
            3'd2:    begin l.enable = 3'b011; l.high = 3'b010; end
            3'd3:    begin l.enable = 3'b110; l.high = 3'b010; end
            3'd4:    begin l.enable = 3'b110; l.high = 3'b100; end
            3'd5:    begin l.enable = 3'b101; l.high = 3'b001; end
            3'd6:    begin l.enable = 3'b101; l.high = 3'b100; end
            default: begin l.enable = 3'b000; l.high = 3'b000; end
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mpld_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module mpld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/multiplexed_pwm_led_dimmer_unit.sv
// Top level of the multiplexed PWM LED dimmer: level store, scan counters,
// charlie slot RAM and the result stage. Uses mpld_pkg and mpld_ram.
`default_nettype none

// Channel  Dir  Width        Contents
// s_       in   tdata 16     led_index, level, slot_index, slot_value
//               tuser 2      mode (tick, set level, set slot, clear all)
// m_       out  tdata 24     led_on, line_enable, line_high (ticks only)
//
// One item per cycle is taken; a tick's result appears in the cycle after its
// transfer, out of the result register and the slot RAM's read register.
// Level, slot and clear items finish in the cycle of their transfer and
// give no result. A stalled result holds the input off until it is taken.
// aresetn (synchronous) zeroes levels, slot valid bits, phase, row, column,
// slot pointer and result valid; the slot RAM itself needs no clearing pass.

module multiplexed_pwm_led_dimmer_unit #(
    parameter int NUM_LEDS = mpld_pkg::DEF_NUM_LEDS,
    parameter int LEVELS   = mpld_pkg::DEF_LEVELS,
    parameter int ROWS     = mpld_pkg::DEF_ROWS,
    parameter int PHASES   = mpld_pkg::DEF_PHASES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [3:0] led_index, [8:4] level, [11:9] slot_index, [14:12] slot_value
    input  wire logic [mpld_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] mode
    input  wire logic [mpld_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [15:0] led_on, [18:16] line_enable, [21:19] line_high
    output logic      [mpld_pkg::OUT_DATA_W-1:0]   m_tdata
);

    import mpld_pkg::*;

    localparam int PHASE_W = $clog2(PHASES);
    localparam int ROW_W   = $clog2(ROWS + 1);
    localparam int COL_W   = $clog2(PHASES / ROWS + 1);

    // Input fields
    mode_t              in_mode;
    logic [3:0]         in_led_index;
    logic [LEVEL_W-1:0] in_level;
    logic [SLOT_AW-1:0] in_slot_index;
    logic [SLOT_W-1:0]  in_slot_value;

    assign in_mode       = mode_t'(s_tuser[1:0]);
    assign in_led_index  = s_tdata[3:0];
    assign in_level      = s_tdata[8:4];
    assign in_slot_index = s_tdata[11:9];
    assign in_slot_value = s_tdata[14:12];

    // State
    logic [LEVEL_W-1:0]    level_reg     [NUM_LEDS];
    logic [LEVEL_W-1:0]    level_next    [NUM_LEDS];
    logic [SLOT_COUNT-1:0] slot_vld_reg, slot_vld_next;
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [SLOT_AW-1:0]    sp_reg, sp_next;

    // Result stage
    logic                  res_vld_reg, res_vld_next;
    logic [MAX_LEDS-1:0]   res_leds_reg, res_leds_next;
    logic                  res_slot_ok_reg, res_slot_ok_next;

    logic                  accept;
    logic                  tick;
    logic                  ram_wr_en;
    logic [SLOT_W-1:0]     ram_rd_data;
    logic [MAX_LEDS-1:0]   lit;
    logic [LEVEL_W-1:0]    rank;
    lines_t                lines;

    // Take a new item whenever the result stage is empty or drains this cycle
    assign s_tready = !res_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (in_mode == MODE_TICK);
    assign ram_wr_en = accept && (in_mode == MODE_SET_SLOT)
                       && (in_slot_index < SLOT_AW'(SLOT_COUNT));

    // LED n is lit when the current row is its row and the column's place
    // in the scrambled order is below its level
    assign rank = col_rank(COL_TAB_W'(col_reg));

    always_comb begin
        lit = '0;
        for (int n = 0; n < NUM_LEDS; n++) begin
            lit[n] = (ROW_TAB_W'(row_reg) == LED_ROW[n]) && (rank < level_reg[n]);
        end
    end

    // Item decode: level writes, slot valid bits, clear all, counter advance
    always_comb begin
        level_next    = level_reg;
        slot_vld_next = slot_vld_reg;
        phase_next    = phase_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        sp_next       = sp_reg;
        if (accept) begin
            unique case (in_mode)
                MODE_SET_LEVEL: begin
                    for (int n = 0; n < NUM_LEDS; n++) begin
                        if (in_led_index == 4'(n)) begin
                            level_next[n] = (in_level > LEVEL_W'(LEVELS)) ?
                                            LEVEL_W'(LEVELS) : in_level;
                        end
                    end
                end
                MODE_SET_SLOT: begin
                    if (ram_wr_en) begin
                        slot_vld_next[in_slot_index] = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    for (int n = 0; n < NUM_LEDS; n++) begin
                        level_next[n] = '0;
                    end
                    slot_vld_next = '0;
                end
                MODE_TICK: begin
                    // Advance phase with its row and column split kept alongside
                    if (phase_reg == PHASE_W'(PHASES - 1)) begin
                        phase_next = '0;
                        row_next   = '0;
                        col_next   = '0;
                    end else begin
                        phase_next = phase_reg + 1'b1;
                        if (row_reg == ROW_W'(ROWS - 1)) begin
                            row_next = '0;
                            col_next = col_reg + 1'b1;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    sp_next = (sp_reg == SLOT_AW'(SLOT_COUNT - 1)) ? '0 : sp_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Load the result stage on a tick; drop it once the sink takes it
    always_comb begin
        res_vld_next     = res_vld_reg;
        res_leds_next    = res_leds_reg;
        res_slot_ok_next = res_slot_ok_reg;
        if (tick) begin
            res_vld_next     = 1'b1;
            res_leds_next    = lit;
            res_slot_ok_next = slot_vld_reg[sp_reg];
        end else if (m_tready) begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < NUM_LEDS; n++) begin
                level_reg[n] <= '0;
            end
            slot_vld_reg <= '0;
            phase_reg    <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            sp_reg       <= '0;
            res_vld_reg  <= 1'b0;
        end else begin
            level_reg    <= level_next;
            slot_vld_reg <= slot_vld_next;
            phase_reg    <= phase_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            sp_reg       <= sp_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_leds_reg    <= res_leds_next;
        res_slot_ok_reg <= res_slot_ok_next;
    end

    // Charlie slot store. A tick reads under the slot pointer; the read
    // register holds while the result stalls, since no other tick is taken.
    // Only one item per cycle, so a read and a write never meet in a cycle.
    mpld_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_slot_index),
        .wr_data (in_slot_value),
        .rd_en   (tick),
        .rd_addr (sp_reg),
        .rd_data (ram_rd_data)
    );

    // An entry never written since reset or clear reads as all lines off
    assign lines = charlie_decode(res_slot_ok_reg ? ram_rd_data : '0);

    assign m_tvalid = res_vld_reg;
    assign m_tdata  = {2'b00, lines.high, lines.enable, res_leds_reg};

endmodule

`default_nettype wire

FILE: tb/multiplexed_pwm_led_dimmer_unit_test.sv
// Self-checking testbench for multiplexed_pwm_led_dimmer_unit: drives level, slot, clear and
// tick transfers and compares every scan result against an in-bench prediction.
// Depends on mpld_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module multiplexed_pwm_led_dimmer_unit_test;
    import mpld_pkg::*;

    localparam int ROWS_USED     = 6;
    localparam int PHASE_COUNT   = 96;
    localparam int LEVEL_CEILING = 16;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_PERCENT  = 27;

    // Charlie LED number to line enable / drive-high bits, indexed by slot value
    localparam logic [2:0] LINE_EN_OF [8] = '{3'd0, 3'd3, 3'd3, 3'd6, 3'd6, 3'd5, 3'd5, 3'd0};
    localparam logic [2:0] LINE_HI_OF [8] = '{3'd0, 3'd1, 3'd2, 3'd2, 3'd4, 3'd1, 3'd4, 3'd0};

    typedef struct {
        logic [15:0] led_on;
        logic [2:0]  line_enable;
        logic [2:0]  line_high;
    } scan_t;

    // Mirror of the dimmer state plus the queue of scans still owed by the unit
    class scan_scoreboard;
        logic [4:0]  level_of [16];
        logic [2:0]  slot_of [6];
        int unsigned phase;
        int unsigned slot_ptr;
        scan_t       expected_scans [$];
        int unsigned mismatches;

        function new();
            foreach (level_of[i]) level_of[i] = '0;
            foreach (slot_of[i]) slot_of[i] = '0;
            phase = 0;
            slot_ptr = 0;
            mismatches = 0;
        endfunction

        function scan_t predict_scan();
            scan_t s;
            int col;
            int row;
            col = phase / ROWS_USED;
            row = phase % ROWS_USED;
            s.led_on = '0;
            for (int n = 0; n < 16; n++) begin
                if (int'(LED_ROW[n]) == row) begin
                    for (int i = 0; i < int'(level_of[n]) && i < 16; i++) begin
                        if (int'(COL_ORDER[i]) == col) s.led_on[n] = 1'b1;
                    end
                end
            end
            s.line_enable = LINE_EN_OF[slot_of[slot_ptr]];
            s.line_high   = LINE_HI_OF[slot_of[slot_ptr]];
            return s;
        endfunction

        // Apply one accepted input transfer to the mirrored state
        function void take_item(mode_t mode, logic [15:0] payload);
            logic [3:0] idx;
            logic [4:0] lvl;
            logic [2:0] si;
            logic [2:0] sv;
            idx = payload[3:0];
            lvl = payload[8:4];
            si  = payload[11:9];
            sv  = payload[14:12];
            case (mode)
                MODE_SET_LEVEL: begin
                    level_of[idx] = (lvl > LEVEL_CEILING) ? 5'(LEVEL_CEILING) : lvl;
                end
                MODE_SET_SLOT: begin
                    if (si < 6) slot_of[si] = sv;
                end
                MODE_CLEAR: begin
                    foreach (level_of[i]) level_of[i] = '0;
                    foreach (slot_of[i]) slot_of[i] = '0;
                end
                default: begin
                    expected_scans.push_back(predict_scan());
                    phase = (phase + 1) % PHASE_COUNT;
                    slot_ptr = (slot_ptr + 1) % 6;
                end
            endcase
        endfunction

        function void check_scan(logic [23:0] word);
            scan_t want;
            if (expected_scans.size() == 0) begin
                $error("unexpected scan result %h", word);
                mismatches++;
                return;
            end
            want = expected_scans.pop_front();
            if (word[15:0] !== want.led_on) begin
                $error("led_on: expected %h, got %h", want.led_on, word[15:0]);
                mismatches++;
            end
            if (word[18:16] !== want.line_enable) begin
                $error("line_enable: expected %b, got %b", want.line_enable, word[18:16]);
                mismatches++;
            end
            if (word[21:19] !== want.line_high) begin
                $error("line_high: expected %b, got %b", want.line_high, word[21:19]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    scan_scoreboard sb;
    bit steady;          // suppress idling on both sides
    bit hold_results;    // ask the result sink for one long hold-off

    multiplexed_pwm_led_dimmer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Generous ceiling: far above the slowest correct run
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Pack the data fields, led_index in the lowest bits, bit 15 padded with zero
    function automatic logic [15:0] item_word(logic [3:0] idx, logic [4:0] lvl,
                                              logic [2:0] si, logic [2:0] sv);
        return {1'b0, sv, si, lvl, idx};
    endfunction

    // Offer one item from a falling edge, hold it until the transfer, return on a falling edge
    task automatic send_item(input mode_t mode, input logic [15:0] payload);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= payload;
        do @(posedge aclk); while (!s_tready);
        sb.take_item(mode, payload);
        @(negedge aclk);
    endtask

    // Drop valid and hold the sender until every owed scan has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.expected_scans.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random item: mostly ticks, with level writes often enough that LEDs light up
    task automatic send_random_item();
        int pick;
        logic [15:0] payload;
        pick = $urandom_range(99);
        payload = item_word(4'($urandom_range(15)), 5'($urandom_range(31)),
                            3'($urandom_range(7)), 3'($urandom_range(7)));
        if (pick < 62)      send_item(MODE_TICK, payload);
        else if (pick < 84) send_item(MODE_SET_LEVEL, payload);
        else if (pick < 98) send_item(MODE_SET_SLOT, payload);
        else                send_item(MODE_CLEAR, payload);
    endtask

    // Result sink: random back-pressure, plus one long hold-off counted here
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(negedge aclk);
                hold_results = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // Check each scan transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_scan(m_tdata);
    end

    initial begin
        sb = new();
        steady = 1'b0;
        hold_results = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_TICK;

        // Hold reset, release on a falling edge
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: tick from reset, level clamps, ignored slot writes,
        // value seven decoding as all lines off, clear leaving the counters running
        send_item(MODE_TICK, item_word(4'd0, 5'd0, 3'd0, 3'd0));
        send_item(MODE_SET_LEVEL, item_word(4'd0, 5'd31, 3'd0, 3'd0));
        send_item(MODE_SET_LEVEL, item_word(4'd15, 5'd16, 3'd7, 3'd7));
        send_item(MODE_SET_LEVEL, item_word(4'd9, 5'd17, 3'd0, 3'd0));
        send_item(MODE_SET_LEVEL, item_word(4'd12, 5'd1, 3'd0, 3'd0));
        send_item(MODE_SET_LEVEL, item_word(4'd1, 5'd0, 3'd0, 3'd0));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd0, 3'd1));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd5, 3'd7));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd6, 3'd3));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd7, 3'd6));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd1, 3'd6));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd2, 3'd3));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd3, 3'd4));
        send_item(MODE_SET_SLOT, item_word(4'd0, 5'd0, 3'd4, 3'd2));
        repeat (7) send_item(MODE_TICK, item_word(4'd15, 5'd31, 3'd7, 3'd7));
        send_item(MODE_CLEAR, item_word(4'd0, 5'd0, 3'd0, 3'd0));
        send_item(MODE_TICK, item_word(4'd0, 5'd0, 3'd0, 3'd0));
        send_item(MODE_SET_LEVEL, item_word(4'd6, 5'd8, 3'd0, 3'd5));
        send_item(MODE_TICK, item_word(4'd0, 5'd0, 3'd0, 3'd0));

        // Random part; one hold-off on the result side, a stretch without idling, one full drain
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k >= 600 && k < 900);
            if (k == 400) hold_results = 1'b1;
            if (k == 1000) drain_results();
            send_random_item();
        end
        steady = 1'b0;

        // Wait for the last scans, then let the pipeline settle
        drain_results();
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mpld_pkg.sv
sv/mpld_ram.sv
sv/multiplexed_pwm_led_dimmer_unit.sv
tb/multiplexed_pwm_led_dimmer_unit_test.sv
